>>> hw/rtl/encfm_pkg.sv
// Shared types, constants and register map of the encoder frequency meter.
`timescale 1ns / 1ps

package encfm_pkg;

   localparam int POSITION_WIDTH_DEF = 32;
   localparam int PERIOD_WIDTH_DEF   = 16;

   localparam int POSITION_FIELD_WIDTH = 32;
   localparam int PERIOD_FIELD_WIDTH   = 16;
   localparam int FREQ_WIDTH           = 31;

   localparam int CLOCK_WIDTH = 32;
   localparam int RATE_WIDTH  = 16;
   localparam int PPRE_WIDTH  = 12;
   localparam int CPRE_WIDTH  = 8;
   localparam int EDGE_WIDTH  = 3;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_INDEX_WIDTH = 3;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_CLOCK_HZ          = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_UNIT_RATE_HZ      = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_POSITION_PRESCALE = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_CAPTURE_PRESCALE  = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_EDGES_PER_CYCLE   = 3'd4;

   localparam logic [CLOCK_WIDTH-1:0] CLOCK_HZ_RESET          = 32'd150000000;
   localparam logic [RATE_WIDTH-1:0]  UNIT_RATE_HZ_RESET      = 16'd100;
   localparam logic [PPRE_WIDTH-1:0]  POSITION_PRESCALE_RESET = 12'd8;
   localparam logic [CPRE_WIDTH-1:0]  CAPTURE_PRESCALE_RESET  = 8'd128;
   localparam logic [EDGE_WIDTH-1:0]  EDGES_PER_CYCLE_RESET   = 3'd2;

   localparam logic ACTION_TIMEOUT = 1'b0;
   localparam logic ACTION_CAPTURE = 1'b1;

   typedef struct packed {
      logic [CLOCK_WIDTH-1:0] clock_hz;
      logic [RATE_WIDTH-1:0]  unit_rate_hz;
      logic [PPRE_WIDTH-1:0]  position_prescale;
      logic [CPRE_WIDTH-1:0]  capture_prescale;
      logic [EDGE_WIDTH-1:0]  edges_per_cycle;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic multiply;
      logic scale;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_full;
   } dp_status_type;

endpackage

>>> hw/rtl/encfm_intf.sv
// Request and response channel interfaces of the encoder frequency meter.
`timescale 1ns / 1ps

interface encfm_req_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        action;
   logic [encfm_pkg::POSITION_FIELD_WIDTH-1:0] latched_position;
   logic [encfm_pkg::PERIOD_FIELD_WIDTH-1:0]   capture_period;
   logic                                        capture_overflow;

   modport source (output valid, action, latched_position, capture_period, capture_overflow,
                   input ready);
   modport sink (input valid, action, latched_position, capture_period, capture_overflow,
                 output ready);
endinterface

interface encfm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              method;
   logic [encfm_pkg::FREQ_WIDTH-1:0] frequency_hz;
   logic                              saturated;

   modport source (output valid, method, frequency_hz, saturated, input ready);
   modport sink (input valid, method, frequency_hz, saturated, output ready);
endinterface

>>> hw/rtl/encoder_frequency_meter.sv
// Top level of the encoder frequency meter.
`timescale 1ns / 1ps

// Usage:
//   req_chan carries one measurement per beat. Action timeout brings the
//   latched position count; the result is the position change since the last
//   timeout beat times unit_rate_hz, divided by edges_per_cycle. Action capture
//   brings a capture period and overflow flag; the result is clock_hz times
//   position_prescale over period times capture_prescale times edges_per_cycle.
//   rsp_chan returns exactly one beat per request beat, in order, with the
//   method, the frequency in hertz and a saturation flag (result clipped to
//   2^31-1, or zero divisor).
//   Registers are to be written over the csr_ port only while the block is
//   idle; the block itself does not enforce this. A request passes through
//   the multiply and scale states, the one-bit-per-cycle restoring divider,
//   which runs one step per numerator bit (48 steps at the default widths),
//   and the load state; a new request is taken only once the block is idle.
//   Reset restores the register defaults and clears the stored position.
//   A stalled response beat is held in the output register; the next request
//   is still taken and computed, then waits until that beat leaves.

module encoder_frequency_meter #(
   parameter int POSITION_WIDTH = encfm_pkg::POSITION_WIDTH_DEF,
   parameter int PERIOD_WIDTH   = encfm_pkg::PERIOD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   encfm_req_if.sink                             req_chan,
   encfm_rsp_if.source                           rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [encfm_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [encfm_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [encfm_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                  csr_pready
);

   encfm_pkg::cfg_type        cfg;
   encfm_pkg::ctrl_cmd_type   cmd;
   encfm_pkg::dp_status_type  status;

   assign csr_pready = 1'b1;

   encfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   encfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .out_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   encfm_datapath #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .PERIOD_WIDTH   (PERIOD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .in_action           (req_chan.action),
      .in_latched_position (req_chan.latched_position),
      .in_capture_period   (req_chan.capture_period),
      .in_capture_overflow (req_chan.capture_overflow),
      .out_ready           (rsp_chan.ready),
      .out_valid           (rsp_chan.valid),
      .out_method          (rsp_chan.method),
      .out_frequency_hz    (rsp_chan.frequency_hz),
      .out_saturated       (rsp_chan.saturated)
   );

endmodule

>>> hw/rtl/encfm_csr.sv
// Configuration register file with APB-style write and read access.
`timescale 1ns / 1ps

module encfm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [encfm_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [encfm_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [encfm_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output encfm_pkg::cfg_type                    cfg
);

   encfm_pkg::cfg_type                          cfg_ff;
   encfm_pkg::cfg_type                          cfg_in;
   logic [encfm_pkg::REG_INDEX_WIDTH-1:0]      index;
   logic                                        wr_en;

   assign index = paddr[encfm_pkg::CSR_ADDR_WIDTH-1:2];
   assign wr_en = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            encfm_pkg::REG_CLOCK_HZ: begin
               cfg_in.clock_hz = pwdata[encfm_pkg::CLOCK_WIDTH-1:0];
            end
            encfm_pkg::REG_UNIT_RATE_HZ: begin
               cfg_in.unit_rate_hz = pwdata[encfm_pkg::RATE_WIDTH-1:0];
            end
            encfm_pkg::REG_POSITION_PRESCALE: begin
               cfg_in.position_prescale = pwdata[encfm_pkg::PPRE_WIDTH-1:0];
            end
            encfm_pkg::REG_CAPTURE_PRESCALE: begin
               cfg_in.capture_prescale = pwdata[encfm_pkg::CPRE_WIDTH-1:0];
            end
            encfm_pkg::REG_EDGES_PER_CYCLE: begin
               cfg_in.edges_per_cycle = pwdata[encfm_pkg::EDGE_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         encfm_pkg::REG_CLOCK_HZ:          prdata = cfg_ff.clock_hz;
         encfm_pkg::REG_UNIT_RATE_HZ:      prdata = 32'(cfg_ff.unit_rate_hz);
         encfm_pkg::REG_POSITION_PRESCALE: prdata = 32'(cfg_ff.position_prescale);
         encfm_pkg::REG_CAPTURE_PRESCALE:  prdata = 32'(cfg_ff.capture_prescale);
         encfm_pkg::REG_EDGES_PER_CYCLE:   prdata = 32'(cfg_ff.edges_per_cycle);
         default:                          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_hz          <= encfm_pkg::CLOCK_HZ_RESET;
         cfg_ff.unit_rate_hz      <= encfm_pkg::UNIT_RATE_HZ_RESET;
         cfg_ff.position_prescale <= encfm_pkg::POSITION_PRESCALE_RESET;
         cfg_ff.capture_prescale  <= encfm_pkg::CAPTURE_PRESCALE_RESET;
         cfg_ff.edges_per_cycle   <= encfm_pkg::EDGES_PER_CYCLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/encfm_ctrl.sv
// Sequencing state machine: accept, multiply, scale, divide, load result.
`timescale 1ns / 1ps

module encfm_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          out_ready,
   input  encfm_pkg::dp_status_type      status,
   output encfm_pkg::ctrl_cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_SCALE = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_LOAD  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (!status.out_full || out_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/encfm_datapath.sv
// Operand latches, multipliers, bit-serial divider and result register.
`timescale 1ns / 1ps

module encfm_datapath #(
   parameter int POSITION_WIDTH = encfm_pkg::POSITION_WIDTH_DEF,
   parameter int PERIOD_WIDTH   = encfm_pkg::PERIOD_WIDTH_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  encfm_pkg::cfg_type                          cfg,
   input  encfm_pkg::ctrl_cmd_type                     cmd,
   output encfm_pkg::dp_status_type                    status,
   input  logic                                        in_action,
   input  logic [encfm_pkg::POSITION_FIELD_WIDTH-1:0] in_latched_position,
   input  logic [encfm_pkg::PERIOD_FIELD_WIDTH-1:0]   in_capture_period,
   input  logic                                        in_capture_overflow,
   input  logic                                        out_ready,
   output logic                                        out_valid,
   output logic                                        out_method,
   output logic [encfm_pkg::FREQ_WIDTH-1:0]           out_frequency_hz,
   output logic                                        out_saturated
);

   localparam int PosProdWidth = POSITION_WIDTH + encfm_pkg::RATE_WIDTH;
   localparam int ClkProdWidth = encfm_pkg::CLOCK_WIDTH + encfm_pkg::PPRE_WIDTH;
   localparam int NumWidth     = (PosProdWidth > ClkProdWidth) ? PosProdWidth : ClkProdWidth;
   localparam int PartWidth    = PERIOD_WIDTH + encfm_pkg::CPRE_WIDTH;
   localparam int DenWidth     = PartWidth + encfm_pkg::EDGE_WIDTH;
   localparam int CountWidth   = $clog2(NumWidth + 1);
   localparam int FreqWidth    = encfm_pkg::FREQ_WIDTH;

   logic                        action_ff, action_in;
   logic [POSITION_WIDTH-1:0]   position_ff, position_in;
   logic [POSITION_WIDTH-1:0]   last_position_ff, last_position_in;
   logic [PERIOD_WIDTH-1:0]     period_ff, period_in;
   logic [NumWidth-1:0]         num_ff, num_in;
   logic [PartWidth-1:0]        part_ff, part_in;
   logic [DenWidth-1:0]         den_ff, den_in;
   logic [DenWidth-1:0]         rem_ff, rem_in;
   logic [CountWidth-1:0]       count_ff, count_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_method_ff, out_method_in;
   logic [FreqWidth-1:0]        out_freq_ff, out_freq_in;
   logic                        out_sat_ff, out_sat_in;

   logic [POSITION_WIDTH-1:0]         diff;
   logic [PosProdWidth-1:0]           pos_prod;
   logic [ClkProdWidth-1:0]           clk_prod;
   logic [encfm_pkg::EDGE_WIDTH-1:0]  edges_or_one;
   logic [DenWidth:0]                 trial;
   logic                              trial_ge;
   logic                              quot_over;

   assign diff     = position_ff - last_position_ff;
   assign pos_prod = PosProdWidth'(diff) * PosProdWidth'(cfg.unit_rate_hz);
   assign clk_prod = ClkProdWidth'(cfg.clock_hz) * ClkProdWidth'(cfg.position_prescale);
   assign edges_or_one = (cfg.edges_per_cycle == '0) ?
                         encfm_pkg::EDGE_WIDTH'(1) : cfg.edges_per_cycle;
   assign trial    = {rem_ff, num_ff[NumWidth-1]};
   assign trial_ge = trial >= {1'b0, den_ff};
   assign quot_over = |num_ff[NumWidth-1:FreqWidth];

   always_comb begin
      action_in        = action_ff;
      position_in      = position_ff;
      last_position_in = last_position_ff;
      period_in        = period_ff;
      num_in           = num_ff;
      part_in          = part_ff;
      den_in           = den_ff;
      rem_in           = rem_ff;
      count_in         = count_ff;
      out_method_in    = out_method_ff;
      out_freq_in      = out_freq_ff;
      out_sat_in       = out_sat_ff;
      if (cmd.load) begin
         action_in   = in_action;
         position_in = in_latched_position[POSITION_WIDTH-1:0];
         period_in   = in_capture_overflow ? '1 : in_capture_period[PERIOD_WIDTH-1:0];
      end
      if (cmd.multiply) begin
         num_in  = (action_ff == encfm_pkg::ACTION_CAPTURE) ?
                   NumWidth'(clk_prod) : NumWidth'(pos_prod);
         part_in = PartWidth'(period_ff) * PartWidth'(cfg.capture_prescale);
         if (action_ff == encfm_pkg::ACTION_TIMEOUT) begin
            last_position_in = position_ff;
         end
      end
      if (cmd.scale) begin
         den_in   = (action_ff == encfm_pkg::ACTION_CAPTURE) ?
                    DenWidth'(part_ff) * DenWidth'(cfg.edges_per_cycle) :
                    DenWidth'(edges_or_one);
         rem_in   = '0;
         count_in = CountWidth'(NumWidth);
      end
      if (cmd.div_step) begin
         rem_in   = trial_ge ? DenWidth'(trial - {1'b0, den_ff}) : trial[DenWidth-1:0];
         num_in   = {num_ff[NumWidth-2:0], trial_ge};
         count_in = count_ff - CountWidth'(1);
      end
      if (cmd.out_load) begin
         out_method_in = action_ff;
         out_sat_in    = quot_over;
         out_freq_in   = quot_over ? '1 : num_ff[FreqWidth-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_position_ff <= '0;
         count_ff         <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         last_position_ff <= last_position_in;
         count_ff         <= count_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      position_ff   <= position_in;
      period_ff     <= period_in;
      num_ff        <= num_in;
      part_ff       <= part_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      out_method_ff <= out_method_in;
      out_freq_ff   <= out_freq_in;
      out_sat_ff    <= out_sat_in;
   end

   assign status.div_last = (count_ff == CountWidth'(1));
   assign status.out_full = out_valid_ff;

   assign out_valid        = out_valid_ff;
   assign out_method       = out_method_ff;
   assign out_frequency_hz = out_freq_ff;
   assign out_saturated    = out_sat_ff;

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || out_ready))
      else $error("result register overwritten while holding a beat");
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (count_ff != '0))
      else $error("divider step with no bits left");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> out_valid_ff)
      else $error("loaded result not presented");
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sat_ff) |-> (out_freq_ff == '1))
      else $error("saturated result not clipped to full scale");
`endif

endmodule
